### rtl/rm2q_pkg.sv
`timescale 1ns / 1ps
package rm2q_pkg;

	localparam int ELEM_W    = 16;
	localparam int NUM_ELEM  = 9;
	localparam int EXT_W     = 20;
	localparam int ROOT_W    = 23;
	localparam int RAD_W     = 46;
	localparam int RAD_SHIFT = 28;
	localparam int REM_W     = 26;
	localparam int MAG_W     = 17;
	localparam int NUM_W     = 38;
	localparam int DSR_W     = 24;
	localparam int QUO_W     = 23;
	localparam int CMP_W     = 46;
	localparam int NUM_SHIFT = 21;

	localparam logic [1:0] SLOT_W = 2'd0;
	localparam logic [1:0] SLOT_X = 2'd1;
	localparam logic [1:0] SLOT_Y = 2'd2;
	localparam logic [1:0] SLOT_Z = 2'd3;

	localparam logic [1:0] DOM_X = 2'd0;
	localparam logic [1:0] DOM_Y = 2'd1;
	localparam logic [1:0] DOM_Z = 2'd2;

	localparam logic signed [EXT_W-1:0] ONE_Q14 = 20'sd16384;
	localparam logic [ELEM_W-1:0] Q_ONE   = 16'h4000;
	localparam logic [ELEM_W-1:0] Q_MAX   = 16'h7fff;
	localparam logic [ELEM_W-1:0] Q_MIN   = 16'h8000;
	localparam logic [QUO_W-1:0]  POS_LIM = 23'd32767;
	localparam logic [QUO_W-1:0]  NEG_LIM = 23'd32768;
	localparam logic [ROOT_W-1:0] ROOT_MIN = 23'd16384;

	typedef struct packed {
		logic       bad;
		logic [1:0] dom_slot;
		logic [1:0] slot_a;
		logic [1:0] slot_b;
		logic [1:0] slot_c;
		logic [2:0] neg;
	} ctl_t;

endpackage

### rtl/rotation_matrix_to_quaternion.sv
`timescale 1ns / 1ps
// pipeline from request accept to result valid: one stage per root or quotient bit
// throughput: one request per cycle; a single enable stalls every stage while the output waits
// 23 square root stages feed 23 divider stages that run three lanes side by side
// reset: arst_n clears all valid bits and the output register, no clearing pass
module rotation_matrix_to_quaternion
	import rm2q_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [143:0] s_axis_tdata,  // rot_00 rot_01 rot_02 rot_10 rot_11 rot_12 rot_20 rot_21 rot_22
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [63:0]  m_axis_tdata,  // quat_w quat_x quat_y quat_z
	output logic [0:0]   m_axis_tuser   // bad_input
);

	logic en;
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// stage 1: trace sign and dominant diagonal
	logic signed [ELEM_W-1:0] m_in [NUM_ELEM];
	logic signed [EXT_W-1:0]  tr_in;
	logic [1:0]               idx_in;
	logic                     v_s1;
	logic signed [ELEM_W-1:0] m_s1 [NUM_ELEM];
	logic                     tpos_s1;
	logic [1:0]               idx_s1;

	always_comb begin
		for (int n = 0; n < NUM_ELEM; n++) begin
			m_in[n] = s_axis_tdata[n*ELEM_W +: ELEM_W];
		end
		tr_in = EXT_W'(m_in[0]) + EXT_W'(m_in[4]) + EXT_W'(m_in[8]);
		idx_in = DOM_X;
		if (m_in[4] > m_in[0]) begin
			idx_in = DOM_Y;
		end
		if (m_in[8] > ((idx_in == DOM_Y) ? m_in[4] : m_in[0])) begin
			idx_in = DOM_Z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1    <= m_in;
			tpos_s1 <= tr_in > 0;
			idx_s1  <= idx_in;
		end
	end

	// stage 2: radicand, numerators and output slots
	logic signed [EXT_W-1:0] e [NUM_ELEM];
	logic signed [EXT_W-1:0] r;
	logic signed [EXT_W-1:0] na, nb, nc;
	ctl_t                    ctl_in;
	logic [2:0][MAG_W-1:0]   mag_in;
	logic [RAD_W-1:0]        rad_in;

	always_comb begin
		for (int n = 0; n < NUM_ELEM; n++) begin
			e[n] = EXT_W'(m_s1[n]);
		end
		ctl_in = '0;
		if (tpos_s1) begin
			r  = e[0] + e[4] + e[8] + ONE_Q14;
			na = e[7] - e[5];
			nb = e[2] - e[6];
			nc = e[3] - e[1];
			ctl_in.dom_slot = SLOT_W;
			ctl_in.slot_a   = SLOT_X;
			ctl_in.slot_b   = SLOT_Y;
			ctl_in.slot_c   = SLOT_Z;
		end else begin
			case (idx_s1)
				DOM_X: begin
					r  = e[0] - e[4] - e[8] + ONE_Q14;
					na = e[7] - e[5];
					nb = e[3] + e[1];
					nc = e[6] + e[2];
					ctl_in.dom_slot = SLOT_X;
					ctl_in.slot_a   = SLOT_W;
					ctl_in.slot_b   = SLOT_Y;
					ctl_in.slot_c   = SLOT_Z;
				end
				DOM_Y: begin
					r  = e[4] - e[8] - e[0] + ONE_Q14;
					na = e[2] - e[6];
					nb = e[7] + e[5];
					nc = e[1] + e[3];
					ctl_in.dom_slot = SLOT_Y;
					ctl_in.slot_a   = SLOT_W;
					ctl_in.slot_b   = SLOT_Z;
					ctl_in.slot_c   = SLOT_X;
				end
				default: begin
					r  = e[8] - e[0] - e[4] + ONE_Q14;
					na = e[3] - e[1];
					nb = e[2] + e[6];
					nc = e[5] + e[7];
					ctl_in.dom_slot = SLOT_Z;
					ctl_in.slot_a   = SLOT_W;
					ctl_in.slot_b   = SLOT_X;
					ctl_in.slot_c   = SLOT_Y;
				end
			endcase
		end
		ctl_in.bad = !tpos_s1 && (r <= 0);
		ctl_in.neg = {nc[EXT_W-1], nb[EXT_W-1], na[EXT_W-1]};
		mag_in[0] = na[EXT_W-1] ? MAG_W'(-na) : MAG_W'(na);
		mag_in[1] = nb[EXT_W-1] ? MAG_W'(-nb) : MAG_W'(nb);
		mag_in[2] = nc[EXT_W-1] ? MAG_W'(-nc) : MAG_W'(nc);
		rad_in = ctl_in.bad ? '0 : {1'b0, r[MAG_W-1:0], {RAD_SHIFT{1'b0}}};
	end

	// square root, one root bit per stage; index 0 is stage 2
	logic                  sq_v_s    [0:ROOT_W];
	logic [RAD_W-1:0]      sq_rad_s  [0:ROOT_W];
	logic [REM_W-1:0]      sq_rem_s  [0:ROOT_W];
	logic [ROOT_W-1:0]     sq_root_s [0:ROOT_W];
	ctl_t                  sq_ctl_s  [0:ROOT_W];
	logic [2:0][MAG_W-1:0] sq_mag_s  [0:ROOT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s[0] <= 1'b0;
		end else if (en) begin
			sq_v_s[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_rad_s[0]  <= rad_in;
			sq_rem_s[0]  <= '0;
			sq_root_s[0] <= '0;
			sq_ctl_s[0]  <= ctl_in;
			sq_mag_s[0]  <= mag_in;
		end
	end

	for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
		logic [REM_W-1:0] rem_n;
		logic [REM_W-1:0] test;
		logic             ge;

		assign rem_n = {sq_rem_s[g][REM_W-3:0], sq_rad_s[g][RAD_W-1 -: 2]};
		assign test  = {1'b0, sq_root_s[g], 2'b01};
		assign ge    = rem_n >= test;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[g+1] <= 1'b0;
			end else if (en) begin
				sq_v_s[g+1] <= sq_v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_rad_s[g+1]  <= {sq_rad_s[g][RAD_W-3:0], 2'b00};
				sq_rem_s[g+1]  <= ge ? (rem_n - test) : rem_n;
				sq_root_s[g+1] <= {sq_root_s[g][ROOT_W-2:0], ge};
				sq_ctl_s[g+1]  <= sq_ctl_s[g];
				sq_mag_s[g+1]  <= sq_mag_s[g];
			end
		end
	end

	// divider prep and lanes, one quotient bit per stage
	logic                  dv_v_s   [0:QUO_W];
	logic [2:0][NUM_W-1:0] dv_num_s [0:QUO_W];
	logic [2:0][QUO_W-1:0] dv_q_s   [0:QUO_W];
	logic [DSR_W-1:0]      dv_d_s   [0:QUO_W];
	logic [ELEM_W-1:0]     dv_dom_s [0:QUO_W];
	ctl_t                  dv_ctl_s [0:QUO_W];

	logic [ROOT_W-1:0] root_f;
	logic [DSR_W-1:0]  dom_sum;
	assign root_f  = sq_root_s[ROOT_W];
	assign dom_sum = DSR_W'(root_f) + DSR_W'(128);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else if (en) begin
			dv_v_s[0] <= sq_v_s[ROOT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				dv_num_s[0][l] <= {sq_mag_s[ROOT_W][l], {NUM_SHIFT{1'b0}}} + NUM_W'(root_f);
			end
			dv_q_s[0]   <= '0;
			dv_d_s[0]   <= {root_f, 1'b0};
			dv_dom_s[0] <= dom_sum[DSR_W-1 -: ELEM_W];
			dv_ctl_s[0] <= sq_ctl_s[ROOT_W];
		end
	end

	for (genvar g = 0; g < QUO_W; g++) begin : g_div
		localparam int SH = QUO_W - 1 - g;
		logic [CMP_W-1:0] dsh;
		logic [2:0]       ge;
		logic [2:0][CMP_W-1:0] diff;

		assign dsh = CMP_W'(dv_d_s[g]) << SH;

		always_comb begin
			for (int l = 0; l < 3; l++) begin
				ge[l]   = CMP_W'(dv_num_s[g][l]) >= dsh;
				diff[l] = CMP_W'(dv_num_s[g][l]) - dsh;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[g+1] <= 1'b0;
			end else if (en) begin
				dv_v_s[g+1] <= dv_v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < 3; l++) begin
					dv_num_s[g+1][l] <= ge[l] ? diff[l][NUM_W-1:0] : dv_num_s[g][l];
					dv_q_s[g+1][l]   <= {dv_q_s[g][l][QUO_W-2:0], ge[l]};
				end
				dv_d_s[g+1]   <= dv_d_s[g];
				dv_dom_s[g+1] <= dv_dom_s[g];
				dv_ctl_s[g+1] <= dv_ctl_s[g];
			end
		end
	end

	// saturation, placement and output register
	ctl_t                   cf;
	logic [2:0][ELEM_W-1:0] lane_v;
	logic [3:0][ELEM_W-1:0] qv;
	logic [QUO_W-1:0]       qq;

	always_comb begin
		cf = dv_ctl_s[QUO_W];
		for (int l = 0; l < 3; l++) begin
			qq = dv_q_s[QUO_W][l];
			if (cf.neg[l]) begin
				lane_v[l] = (qq >= NEG_LIM) ? Q_MIN : ELEM_W'(-qq);
			end else begin
				lane_v[l] = (qq > POS_LIM) ? Q_MAX : qq[ELEM_W-1:0];
			end
		end
		qv = '0;
		if (cf.bad) begin
			qv[SLOT_W] = Q_ONE;
		end else begin
			qv[cf.dom_slot] = dv_dom_s[QUO_W][ELEM_W-1] ? Q_MAX : dv_dom_s[QUO_W];
			qv[cf.slot_a]   = lane_v[0];
			qv[cf.slot_b]   = lane_v[1];
			qv[cf.slot_c]   = lane_v[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
			m_axis_tuser  <= '0;
		end else if (en) begin
			m_axis_tvalid <= dv_v_s[QUO_W];
			m_axis_tdata  <= qv;
			m_axis_tuser  <= cf.bad;
		end
	end

	a_bad_identity: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == {48'h0, Q_ONE})
		else $error("bad input without identity result");

	a_root_min: assert property (@(posedge clk) disable iff (!arst_n)
		sq_v_s[ROOT_W] && !sq_ctl_s[ROOT_W].bad |-> sq_root_s[ROOT_W] >= ROOT_MIN)
		else $error("root below one for positive radicand");

	a_slots_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		dv_v_s[QUO_W] |-> cf.dom_slot != cf.slot_a && cf.dom_slot != cf.slot_b &&
			cf.dom_slot != cf.slot_c && cf.slot_a != cf.slot_b &&
			cf.slot_a != cf.slot_c && cf.slot_b != cf.slot_c)
		else $error("output slots overlap");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import rm2q_pkg::*;

	typedef struct packed {
		logic [15:0] w;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
		logic        bad;
	} quat_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [143:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [63:0]  m_axis_tdata;
	logic [0:0]   m_axis_tuser;

	logic [143:0] pending_mats[$];
	quat_t        expected_quats[$];
	int           send_idle_pct;
	int           recv_idle_pct;
	int           hold_cycles;
	int           cycle_count;
	int           error_count;
	bit           in_taken;
	bit           hold_go;
	bit           hold_seen;

	rotation_matrix_to_quaternion dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned rem, res, b;
		rem = v;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (rem >= res + b) begin
				rem = rem - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic longint clamp16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic longint round_quotient(longint n, longint unsigned s);
		longint unsigned mag, q;
		mag = longint'(n < 0 ? -n : n) << 20;
		if (s % 2 == 0) q = (mag + s / 2) / s;
		else q = (2 * mag + s) / (2 * s);
		return clamp16(n < 0 ? -longint'(q) : longint'(q));
	endfunction

	function automatic quat_t convert_matrix(logic [143:0] d);
		longint m[3][3];
		longint q[4];
		longint rad;
		longint unsigned s;
		int i, j, k;
		quat_t res;
		for (int n = 0; n < 9; n++) m[n / 3][n % 3] = longint'($signed(d[n*16 +: 16]));
		res.bad = 1'b0;
		if (m[0][0] + m[1][1] + m[2][2] > 0) begin
			rad = m[0][0] + m[1][1] + m[2][2] + 16384;
			s = int_sqrt(longint'(rad) << 28);
			q[0] = clamp16(longint'((s + 128) >> 8));
			q[1] = round_quotient(m[2][1] - m[1][2], s);
			q[2] = round_quotient(m[0][2] - m[2][0], s);
			q[3] = round_quotient(m[1][0] - m[0][1], s);
		end else begin
			i = 0;
			if (m[1][1] > m[0][0]) i = 1;
			if (m[2][2] > m[i][i]) i = 2;
			j = (i + 1) % 3;
			k = (j + 1) % 3;
			rad = m[i][i] - m[j][j] - m[k][k] + 16384;
			if (rad <= 0) begin
				res.bad = 1'b1;
				q[0] = 16384;
				q[1] = 0;
				q[2] = 0;
				q[3] = 0;
			end else begin
				s = int_sqrt(longint'(rad) << 28);
				q[1 + i] = clamp16(longint'((s + 128) >> 8));
				q[0] = round_quotient(m[k][j] - m[j][k], s);
				q[1 + j] = round_quotient(m[j][i] + m[i][j], s);
				q[1 + k] = round_quotient(m[k][i] + m[i][k], s);
			end
		end
		res.w = q[0][15:0];
		res.x = q[1][15:0];
		res.y = q[2][15:0];
		res.z = q[3][15:0];
		return res;
	endfunction

	function automatic logic [143:0] pack_matrix(int e[9]);
		logic [143:0] d;
		for (int n = 0; n < 9; n++) d[n*16 +: 16] = e[n][15:0];
		return d;
	endfunction

	// rotation-like matrix about one axis from the cos/sin terms given by the caller, plus small noise
	function automatic logic [143:0] rotation_like(int axis, int c, int s, int noise);
		int e[9];
		for (int n = 0; n < 9; n++) e[n] = $urandom_range(2 * noise, 0) - noise;
		case (axis)
			0: begin
				e[0] += 16384; e[4] += c; e[5] -= s; e[7] += s; e[8] += c;
			end
			1: begin
				e[4] += 16384; e[0] += c; e[2] += s; e[6] -= s; e[8] += c;
			end
			default: begin
				e[8] += 16384; e[0] += c; e[1] -= s; e[3] += s; e[4] += c;
			end
		endcase
		for (int n = 0; n < 9; n++) e[n] = clamp16(e[n]);
		return pack_matrix(e);
	endfunction

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || in_taken) begin
				if (pending_mats.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= pending_mats.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver, with one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_go && !hold_seen) begin
				hold_seen     <= 1'b1;
				hold_cycles   <= 300;
				m_axis_tready <= 1'b0;
			end else if (hold_cycles > 0) begin
				m_axis_tready <= 1'b0;
				hold_cycles   <= hold_cycles - 1;
			end else begin
				m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
			end
		end
	end

	// predictor runs at request accept
	always @(posedge clk) begin
		in_taken = arst_n && s_axis_tvalid && s_axis_tready;
		if (in_taken)
			expected_quats.push_back(convert_matrix(s_axis_tdata));
	end

	// monitor
	always @(posedge clk) begin
		quat_t exp_q;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_quats.size() == 0) begin
				$error("result with no request pending");
				error_count++;
			end else begin
				exp_q = expected_quats.pop_front();
				if (m_axis_tdata[15:0] !== exp_q.w) begin
					$error("quat_w exp %h got %h", exp_q.w, m_axis_tdata[15:0]);
					error_count++;
				end
				if (m_axis_tdata[31:16] !== exp_q.x) begin
					$error("quat_x exp %h got %h", exp_q.x, m_axis_tdata[31:16]);
					error_count++;
				end
				if (m_axis_tdata[47:32] !== exp_q.y) begin
					$error("quat_y exp %h got %h", exp_q.y, m_axis_tdata[47:32]);
					error_count++;
				end
				if (m_axis_tdata[63:48] !== exp_q.z) begin
					$error("quat_z exp %h got %h", exp_q.z, m_axis_tdata[63:48]);
					error_count++;
				end
				if (m_axis_tuser[0] !== exp_q.bad) begin
					$error("bad_input exp %b got %b", exp_q.bad, m_axis_tuser[0]);
					error_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 400000) begin
			$display("testbench: errors");
			$finish;
		end
	end

	task automatic run_phase(int send_pct, int recv_pct, int count);
		int e[9];
		int cs[6][2];
		int sel;
		cs = '{'{16384, 0}, '{0, 16384}, '{-16384, 0}, '{11585, 11585},
			'{-11585, 11585}, '{-16384, 1}};
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(9, 0);
			if (sel < 6) begin
				pending_mats.push_back(rotation_like($urandom_range(2, 0),
					cs[$urandom_range(5, 0)][0] * (sel < 3 ? 1 : 1),
					cs[$urandom_range(5, 0)][1], $urandom_range(3, 0) == 0 ? 2000 : 40));
			end else begin
				for (int t = 0; t < 9; t++) e[t] = $urandom_range(65535, 0) - 32768;
				pending_mats.push_back(pack_matrix(e));
			end
		end
		while (pending_mats.size() != 0) @(posedge clk);
	endtask

	initial begin
		int e[9];
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		arst_n = 1'b0;
		cycle_count = 0;
		error_count = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: identity, axis flips, trace zero, ties, extremes
		e = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}; pending_mats.push_back(pack_matrix(e));
		e = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; pending_mats.push_back(pack_matrix(e));
		e = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384}; pending_mats.push_back(pack_matrix(e));
		e = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384}; pending_mats.push_back(pack_matrix(e));
		e = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; pending_mats.push_back(pack_matrix(e));
		e = '{100, 5, -7, 9, 100, 3, 1, 2, -200}; pending_mats.push_back(pack_matrix(e));
		e = '{-100, 5, -7, 9, -100, 3, 1, 2, 200}; pending_mats.push_back(pack_matrix(e));
		e = '{-8192, 0, 0, 0, -8192, 0, 0, 0, -8192}; pending_mats.push_back(pack_matrix(e));
		e = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768};
		pending_mats.push_back(pack_matrix(e));
		e = '{32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767};
		pending_mats.push_back(pack_matrix(e));
		e = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
		pending_mats.push_back(pack_matrix(e));
		e = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
		pending_mats.push_back(pack_matrix(e));
		e = '{-16383, 32767, -32768, -32768, -16384, 32767, 32767, -32768, -16384};
		pending_mats.push_back(pack_matrix(e));
		e = '{1, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0};
		pending_mats.push_back(pack_matrix(e));
		e = '{-1, 0, 0, 0, 0, 0, 0, 0, 0}; pending_mats.push_back(pack_matrix(e));
		e = '{0, 0, 0, 0, 16384, 0, 0, 0, -16384}; pending_mats.push_back(pack_matrix(e));
		e = '{11585, -11585, 0, 11585, 11585, 0, 0, 0, 16384};
		pending_mats.push_back(pack_matrix(e));
		run_phase(28, 77, 0);

		run_phase(28, 77, 500);
		// long hold-off on the receiver while the sender keeps offering
		hold_go = 1'b1;
		run_phase(28, 77, 200);
		run_phase(77, 28, 450);
		run_phase(0, 0, 400);

		while (expected_quats.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (error_count == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule

### files.f
rtl/rm2q_pkg.sv
rtl/rotation_matrix_to_quaternion.sv
tb/testbench.sv
